/* rtl/htfd_pkg.sv */
// Package for the humidity and temperature frame decoder.
// Holds the payload types, the frame position codes, the scaling constants and the CRC byte step.
// No dependencies.
package htfd_pkg;

  typedef logic signed [14:0] temp_centi_t;
  typedef logic [13:0]        hum_centi_t;

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* rtl/htfd_if.sv */
// Channel interfaces of the frame decoder: received bytes in, decoded measurements out.
// Depends on htfd_pkg for the payload types.
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
  logic                 valid;
  logic                 ready;
  logic                 status;
  htfd_pkg::temp_centi_t temperature_centi;
  htfd_pkg::hum_centi_t  humidity_centi;

  modport source (output valid, output status, output temperature_centi,
                  output humidity_centi, input ready);
  modport sink (input valid, input status, input temperature_centi,
                input humidity_centi, output ready);
endinterface

/* rtl/humidity_temp_frame_decoder.sv */
// Top level of the humidity and temperature frame decoder: CRC check and scaling of six-byte frames.
// Depends on htfd_pkg, htfd_in_if, htfd_out_if and htfd_fold.
//
//   channel   direction  beat payload
//   in_bus    sink       rx_byte, frame_start
//   out_bus   source     status, temperature_centi, humidity_centi
//
// One byte is taken per cycle while the input is not stalled; the result of a frame is offered
// in the cycle after its sixth byte. The raw words are multiplied into registers as their low
// bytes arrive, and the sixth byte folds both products into the result register.
// A held result that the receiver does not take stalls the input while the decoder waits for
// the sixth byte of a frame.
// Reset is synchronous and returns the decoder to byte zero with no result pending.
module humidity_temp_frame_decoder (
  input logic       clk,
  input logic       rst_n,
  htfd_in_if.sink   in_bus,
  htfd_out_if.source out_bus
);

  htfd_pkg::pos_t pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_step;
  logic [7:0]  held_r;
  logic        temp_good_r, temp_good_nxt;
  logic [30:0] temp_prod_r, hum_prod_r;
  logic [14:0] temp_q, hum_q;
  logic        accept, last_byte, frame_ok;

  logic                  out_valid_r;
  logic                  status_r;
  htfd_pkg::temp_centi_t temp_r;
  htfd_pkg::hum_centi_t  hum_r;

  assign in_bus.ready = !out_valid_r || out_bus.ready || (pos_r != htfd_pkg::POS_H_CRC);
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    if (in_bus.frame_start) begin
      pos_eff = htfd_pkg::POS_T_HI;
    end else begin
      pos_eff = pos_r;
    end
    last_byte = (pos_eff == htfd_pkg::POS_H_CRC);
    frame_ok  = temp_good_r && (crc_r == in_bus.rx_byte);
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    temp_good_nxt = temp_good_r;
    crc_step  = htfd_pkg::crc8_step(crc_r, in_bus.rx_byte);
    unique case (pos_eff)
      htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
        crc_step = htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, in_bus.rx_byte);
        crc_nxt  = crc_step;
      end
      htfd_pkg::POS_T_LO, htfd_pkg::POS_H_LO: begin
        crc_nxt = crc_step;
      end
      htfd_pkg::POS_T_CRC: begin
        temp_good_nxt = (crc_r == in_bus.rx_byte);
        crc_nxt       = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_CRC: begin
        crc_nxt = htfd_pkg::CRC_INIT;
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
    if (last_byte) begin
      pos_nxt = htfd_pkg::POS_T_HI;
    end else begin
      pos_nxt = htfd_pkg::pos_t'(pos_eff + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfd_pkg::POS_T_HI;
      crc_r       <= htfd_pkg::CRC_INIT;
      held_r      <= 8'd0;
      temp_good_r <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_good_r <= temp_good_nxt;
      if (pos_eff == htfd_pkg::POS_T_HI || pos_eff == htfd_pkg::POS_H_HI) begin
        held_r <= in_bus.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_eff == htfd_pkg::POS_T_LO) begin
      temp_prod_r <= {15'd0, held_r, in_bus.rx_byte} * {16'd0, htfd_pkg::TEMP_SPAN};
    end
    if (accept && pos_eff == htfd_pkg::POS_H_LO) begin
      hum_prod_r <= {1'b0, {14'd0, held_r, in_bus.rx_byte} * {16'd0, htfd_pkg::HUM_SPAN}};
    end
  end

  htfd_fold u_temp_fold (
    .prod (temp_prod_r),
    .quot (temp_q)
  );

  htfd_fold u_hum_fold (
    .prod (hum_prod_r),
    .quot (hum_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      status_r <= !frame_ok;
      if (frame_ok) begin
        temp_r <= htfd_pkg::temp_centi_t'(temp_q - htfd_pkg::TEMP_OFFSET);
        hum_r  <= hum_q[13:0];
      end else begin
        temp_r <= '0;
        hum_r  <= '0;
      end
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.status            = status_r;
  assign out_bus.temperature_centi = temp_r;
  assign out_bus.humidity_centi    = hum_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == htfd_pkg::POS_T_HI || pos_r == htfd_pkg::POS_T_LO ||
    pos_r == htfd_pkg::POS_T_CRC || pos_r == htfd_pkg::POS_H_HI ||
    pos_r == htfd_pkg::POS_H_LO || pos_r == htfd_pkg::POS_H_CRC)
    else $error("frame position out of range");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept) && $past(last_byte) && pos_r == htfd_pkg::POS_T_HI)
    else $error("result raised without a sixth byte");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> temp_r == '0 && hum_r == '0)
    else $error("mismatch result carries nonzero values");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !status_r |-> hum_r <= 14'd10000 &&
      temp_r >= -15'sd4500 && temp_r <= 15'sd13000)
    else $error("decoded value out of range");

endmodule

/* rtl/htfd_fold.sv */
// Quotient of a scaled raw word by full scale (65535), without a divider.
// Depends on htfd_pkg for the full-scale constant.
module htfd_fold (
  input  logic [30:0] prod,
  output logic [14:0] quot
);

  logic [14:0] q0;
  logic [16:0] rem;

  // x = q0 * 65536 + lo = q0 * 65535 + (q0 + lo); the remainder stays below twice 65535.
  always_comb begin
    q0   = prod[30:16];
    rem  = {1'b0, prod[15:0]} + {2'b00, q0};
    quot = q0 + {14'd0, (rem >= htfd_pkg::FULL_SCALE)};
  end

endmodule

/* dv/htfd_frame_checker.sv */
// Watches the byte and result channels of the humidity and temperature frame decoder.
// Keeps its own frame decoder state and compares each result beat with the decoded frame.
// Depends on htfd_pkg, htfd_in_if and htfd_out_if.
module htfd_frame_checker (
  input  logic clk,
  input  logic rst_n,
  htfd_in_if   in_mon,
  htfd_out_if  out_mon,
  output int   fail_count,
  output int   waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  status;
    htfd_pkg::temp_centi_t temperature;
    htfd_pkg::hum_centi_t  humidity;
  } meas_t;

  meas_t          expected_meas[$];
  htfd_pkg::pos_t frame_pos;
  logic [7:0]     crc_acc;
  logic [7:0]     high_byte;
  logic [15:0]    temp_raw;
  logic [15:0]    hum_raw;
  logic           temp_crc_ok;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    r = crc ^ d;
    repeat (8) r = r[7] ? ((r << 1) ^ htfd_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic meas_t scale_frame(input logic ok, input logic [15:0] t,
                                        input logic [15:0] h);
    logic [31:0] tq;
    logic [31:0] hq;
    meas_t       m;
    m = '0;
    m.status = 1'b1;
    if (ok) begin
      tq = (32'(t) * 32'(htfd_pkg::TEMP_SPAN)) / 32'(htfd_pkg::FULL_SCALE);
      hq = (32'(h) * 32'(htfd_pkg::HUM_SPAN)) / 32'(htfd_pkg::FULL_SCALE);
      m.status = 1'b0;
      m.temperature = htfd_pkg::temp_centi_t'(tq[14:0] - htfd_pkg::TEMP_OFFSET);
      m.humidity = hq[13:0];
    end
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fs);
    htfd_pkg::pos_t p;
    p = frame_pos;
    if (fs || p > htfd_pkg::POS_H_CRC) p = htfd_pkg::POS_T_HI;
    case (p)
      htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
        crc_acc = crc_byte(htfd_pkg::CRC_INIT, b);
        high_byte = b;
      end
      htfd_pkg::POS_T_LO: begin
        crc_acc = crc_byte(crc_acc, b);
        temp_raw = {high_byte, b};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_crc_ok = (crc_acc == b);
        crc_acc = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_LO: begin
        crc_acc = crc_byte(crc_acc, b);
        hum_raw = {high_byte, b};
      end
      default: begin
        expected_meas.push_back(scale_frame(temp_crc_ok && (crc_acc == b), temp_raw, hum_raw));
        crc_acc = htfd_pkg::CRC_INIT;
      end
    endcase
    frame_pos = (p == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_HI : htfd_pkg::pos_t'(p + 3'd1);
  endtask

  always @(posedge clk) begin
    meas_t want;
    if (!rst_n) begin
      fail_count = 0;
      frame_pos = htfd_pkg::POS_T_HI;
      crc_acc = htfd_pkg::CRC_INIT;
      high_byte = '0;
      temp_raw = '0;
      hum_raw = '0;
      temp_crc_ok = 1'b0;
      expected_meas.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        absorb_byte(in_mon.rx_byte, in_mon.frame_start);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_meas.size() == 0) begin
          report_mismatch("result beat with no decoded frame pending");
        end else begin
          want = expected_meas.pop_front();
          if (out_mon.status !== want.status) begin
            report_mismatch($sformatf("status %0b, expected %0b", out_mon.status, want.status));
          end
          if (out_mon.temperature_centi !== want.temperature) begin
            report_mismatch($sformatf("temperature_centi %0d, expected %0d",
                                      out_mon.temperature_centi, want.temperature));
          end
          if (out_mon.humidity_centi !== want.humidity) begin
            report_mismatch($sformatf("humidity_centi %0d, expected %0d",
                                      out_mon.humidity_centi, want.humidity));
          end
        end
      end
    end
    waiting <= expected_meas.size();
  end

endmodule

/* dv/tb_humidity_temp_frame_decoder.sv */
// Top of the frame decoder testbench: clock, reset, byte stimulus, result back-pressure, verdict.
// Depends on htfd_pkg, htfd_in_if, htfd_out_if, htfd_frame_checker and the decoder itself.
module tb_humidity_temp_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 100000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PHASE_BYTES     = 122;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   waiting;
  int   bytes_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;
  logic need_sync = 1'b0;
  int   idle_tab[4] = '{0, 58, 0, 27};
  int   stall_tab[4] = '{0, 0, 58, 27};

  htfd_in_if  in_bus();
  htfd_out_if out_bus();

  always #4 clk = ~clk;

  humidity_temp_frame_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  htfd_frame_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .fail_count(fail_count),
    .waiting   (waiting)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_OFF_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [15:0] pick_word();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.rx_byte <= b;
    in_bus.frame_start <= fs;
    bytes_sent++;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs0,
                            input logic bad_t, input logic bad_h);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = htfd_pkg::crc8_step(htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, t[15:8]), t[7:0]);
    h_crc = htfd_pkg::crc8_step(htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, h[15:8]), h[7:0]);
    if (bad_t) t_crc ^= 8'($urandom_range(1, 255));
    if (bad_h) h_crc ^= 8'($urandom_range(1, 255));
    send_byte(t[15:8], fs0);
    send_byte(t[7:0], 1'b0);
    send_byte(t_crc, 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h_crc, 1'b0);
  endtask

  task automatic send_noise(input int n, input logic fs0);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(255)), (i == 0) ? fs0 : ($urandom_range(7) == 0));
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int kind;
    in_bus.valid <= 1'b0;
    in_bus.rx_byte <= '0;
    in_bus.frame_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0);
    send_noise(3, 1'b1);
    send_frame(16'h6666, 16'h1234, 1'b1, 1'b0, 1'b1);

    hold_tgl <= ~hold_tgl;
    for (int i = 0; i < 3; i++) begin
      send_frame(pick_word(), pick_word(), 1'($urandom_range(1)), 1'b0, 1'b0);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct <= stall_tab[ph];
      while (bytes_sent < 60 + (ph + 1) * PHASE_BYTES) begin
        kind = $urandom_range(99);
        if (kind < 80) begin
          send_frame(pick_word(), pick_word(), need_sync | 1'($urandom_range(1)),
                     $urandom_range(9) == 0, $urandom_range(9) == 0);
          need_sync = 1'b0;
        end else begin
          send_noise($urandom_range(1, 5), 1'($urandom_range(1)));
          need_sync = 1'b1;
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
